// ----- sv/vrl_pkg.sv -----
// ----------------------------------------------------------------------------
// vrl_pkg
// Shared types and constants of the velocity ramp limiter.
// ----------------------------------------------------------------------------
`default_nettype none

package vrl_pkg;

    localparam int SPD_W      = 16;
    localparam int LIM_W      = 15;
    localparam int MS_W       = 16;
    localparam int ELAPSED_W  = 20;
    localparam int NUM_W      = 26;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [SPD_W-1:0] OVER_LEVEL      = 16'sd3000;
    localparam logic [MS_W-1:0]         DEFAULT_RAMP_MS = 16'd100;
    localparam logic [NUM_W-1:0]        US_PER_MS       = 26'd1000;
    localparam logic [LIM_W-1:0]        LINE_LIMIT_RST  = 15'd1500;
    localparam logic [LIM_W-1:0]        TURN_LIMIT_RST  = 15'd8000;

    localparam logic [CFG_ADDR_W-1:0] CFG_LINE_LIMIT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN_LIMIT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIN_ACCEL  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LIN_DECEL  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN_ACCEL = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN_DECEL = 3'd5;

    typedef struct packed {
        logic signed [SPD_W-1:0] linear_cmd;
        logic signed [SPD_W-1:0] turn_cmd;
        logic [ELAPSED_W-1:0]    elapsed_us;
    } t_in_word;

    typedef struct packed {
        logic                    speed_alarm;
        logic signed [SPD_W-1:0] linear_out;
        logic signed [SPD_W-1:0] turn_out;
    } t_out_word;

    typedef struct packed {
        logic                    speed_alarm;
        logic signed [SPD_W-1:0] lin_tgt;
        logic signed [SPD_W-1:0] turn_tgt;
        logic [ELAPSED_W-1:0]    elapsed_us;
        logic [LIM_W-1:0]        line_limit;
        logic [LIM_W-1:0]        turn_limit;
        logic [MS_W-1:0]         lin_acc_ms;
        logic [MS_W-1:0]         lin_dec_ms;
        logic [MS_W-1:0]         turn_acc_ms;
        logic [MS_W-1:0]         turn_dec_ms;
    } t_entry;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

// ----- sv/velocity_ramp_limiter.sv -----
// ----------------------------------------------------------------------------
// velocity_ramp_limiter
// Dual-channel slew-rate limiter for a linear and an angular speed command.
//
// Channel    Direction  Handshake               Word
// input      in         i_in_valid/o_in_stall   t_in_word
// output     out        o_out_valid/i_out_stall t_out_word
// config     in         i_cfg_wr_en             i_cfg_addr, i_cfg_wdata
//
// Each word's ramp steps are worked out on the shared bit-serial divider:
// up to two divisions of 26 steps for each channel. Zero elapsed time skips
// the divisions. Reset is synchronous and active low; it restores the
// register defaults and zeroes both smoothed speeds. The queue holds
// QUEUE_DEPTH words, so the input keeps taking words while the back part
// works or the output is stalled, until the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module velocity_ramp_limiter #(
    parameter int QUEUE_DEPTH = vrl_pkg::QUEUE_DEPTH
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [vrl_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [vrl_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire vrl_pkg::t_in_word              i_in_word,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output vrl_pkg::t_out_word                  o_out_word
);

    logic            q_push;
    logic            q_pop;
    logic            q_full;
    logic            q_empty;
    vrl_pkg::t_entry q_wdata;
    vrl_pkg::t_entry q_rdata;

    vrl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_stall  (o_in_stall),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_wdata)
    );

    vrl_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    vrl_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

// ----- sv/vrl_front.sv -----
// ----------------------------------------------------------------------------
// vrl_front
// Holds the configuration, accepts input words and turns each into a queue
// entry with its over-speed flag, clamped targets and resolved ramp times.
// ----------------------------------------------------------------------------
`default_nettype none

module vrl_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_wr_en,
    input  wire logic [vrl_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [vrl_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  wire logic                             i_in_valid,
    input  wire vrl_pkg::t_in_word                i_in_word,
    output logic                                  o_in_stall,
    input  wire logic                             i_q_full,
    output logic                                  o_q_push,
    output vrl_pkg::t_entry                       o_q_data
);

    logic [vrl_pkg::LIM_W-1:0] r_line_limit;
    logic [vrl_pkg::LIM_W-1:0] r_turn_limit;
    logic [vrl_pkg::MS_W-1:0]  r_lin_acc;
    logic [vrl_pkg::MS_W-1:0]  r_lin_dec;
    logic [vrl_pkg::MS_W-1:0]  r_turn_acc;
    logic [vrl_pkg::MS_W-1:0]  r_turn_dec;

    logic signed [vrl_pkg::SPD_W-1:0] lin_lim;
    logic signed [vrl_pkg::SPD_W-1:0] turn_lim;
    logic signed [vrl_pkg::SPD_W-1:0] vx;
    logic signed [vrl_pkg::SPD_W-1:0] rz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= vrl_pkg::LINE_LIMIT_RST;
            r_turn_limit <= vrl_pkg::TURN_LIMIT_RST;
            r_lin_acc    <= '0;
            r_lin_dec    <= '0;
            r_turn_acc   <= '0;
            r_turn_dec   <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                vrl_pkg::CFG_LINE_LIMIT: r_line_limit <= i_cfg_wdata[vrl_pkg::LIM_W-1:0];
                vrl_pkg::CFG_TURN_LIMIT: r_turn_limit <= i_cfg_wdata[vrl_pkg::LIM_W-1:0];
                vrl_pkg::CFG_LIN_ACCEL:  r_lin_acc    <= i_cfg_wdata;
                vrl_pkg::CFG_LIN_DECEL:  r_lin_dec    <= i_cfg_wdata;
                vrl_pkg::CFG_TURN_ACCEL: r_turn_acc   <= i_cfg_wdata;
                vrl_pkg::CFG_TURN_DECEL: r_turn_dec   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign o_in_stall = i_q_full;
    assign o_q_push   = i_in_valid && !i_q_full;

    assign lin_lim  = $signed({1'b0, r_line_limit});
    assign turn_lim = $signed({1'b0, r_turn_limit});
    assign vx       = i_in_word.linear_cmd;
    assign rz       = i_in_word.turn_cmd;

    always_comb begin
        o_q_data.speed_alarm = (vx > vrl_pkg::OVER_LEVEL) || (vx < -vrl_pkg::OVER_LEVEL);
        if (vx > lin_lim) begin
            o_q_data.lin_tgt = lin_lim;
        end else if (vx < -lin_lim) begin
            o_q_data.lin_tgt = -lin_lim;
        end else begin
            o_q_data.lin_tgt = vx;
        end
        if (rz > turn_lim) begin
            o_q_data.turn_tgt = turn_lim;
        end else if (rz < -turn_lim) begin
            o_q_data.turn_tgt = -turn_lim;
        end else begin
            o_q_data.turn_tgt = rz;
        end
        o_q_data.elapsed_us  = i_in_word.elapsed_us;
        o_q_data.line_limit  = r_line_limit;
        o_q_data.turn_limit  = r_turn_limit;
        o_q_data.lin_acc_ms  = (r_lin_acc == '0) ? vrl_pkg::DEFAULT_RAMP_MS : r_lin_acc;
        o_q_data.lin_dec_ms  = (r_lin_dec == '0) ? vrl_pkg::DEFAULT_RAMP_MS : r_lin_dec;
        o_q_data.turn_acc_ms = (r_turn_acc == '0) ? vrl_pkg::DEFAULT_RAMP_MS : r_turn_acc;
        o_q_data.turn_dec_ms = (r_turn_dec == '0) ? vrl_pkg::DEFAULT_RAMP_MS : r_turn_dec;
    end

endmodule

`default_nettype wire

// ----- sv/vrl_fifo.sv -----
// ----------------------------------------------------------------------------
// vrl_fifo
// Short queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module vrl_fifo #(
    parameter int DEPTH = vrl_pkg::QUEUE_DEPTH
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire vrl_pkg::t_entry i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output vrl_pkg::t_entry      o_data,
    output logic                 o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    vrl_pkg::t_entry r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != FULL))
        else $error("Queue written while full.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("Queue read while empty.");

endmodule

`default_nettype wire

// ----- sv/vrl_div.sv -----
// ----------------------------------------------------------------------------
// vrl_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module vrl_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [vrl_pkg::NUM_W-1:0]  i_num,
    input  wire logic [vrl_pkg::NUM_W-1:0]  i_den,
    output vrl_pkg::t_div_stat              o_stat,
    output logic [vrl_pkg::NUM_W-1:0]       o_quo
);

    localparam int NW    = vrl_pkg::NUM_W;
    localparam int CNT_W = $clog2(NW + 1);

    logic [NW-1:0]    r_rem;
    logic [NW-1:0]    r_quo;
    logic [NW-1:0]    r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [NW:0] rem_sh;
    logic [NW:0] diff;
    logic        ge;

    assign rem_sh = {r_rem, r_quo[NW-1]};
    assign diff   = rem_sh - {1'b0, r_den};
    assign ge     = (rem_sh >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[NW-1:0] : rem_sh[NW-1:0];
            r_quo <= {r_quo[NW-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire

// ----- sv/vrl_back.sv -----
// ----------------------------------------------------------------------------
// vrl_back
// Takes queue entries, works out the ramp step of each channel on the
// shared divider, moves the smoothed speeds and registers the result word.
// ----------------------------------------------------------------------------
`default_nettype none

module vrl_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_empty,
    input  wire vrl_pkg::t_entry i_q_data,
    output logic                 o_q_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output vrl_pkg::t_out_word   o_out_word
);

    localparam int SW = vrl_pkg::SPD_W;
    localparam int LW = vrl_pkg::LIM_W;
    localparam int NW = vrl_pkg::NUM_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SETUP  = 3'd1;
    localparam logic [2:0] ST_DIV_Q  = 3'd2;
    localparam logic [2:0] ST_DIV_S  = 3'd3;
    localparam logic [2:0] ST_UPDATE = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]               r_state;
    logic                     r_chan;
    vrl_pkg::t_entry          r_item;
    logic [LW-1:0]            r_step;
    logic signed [SW-1:0]     r_lin;
    logic signed [SW-1:0]     r_turn;
    logic                     r_out_valid;
    vrl_pkg::t_out_word       r_out;

    logic [LW-1:0]            lim;
    logic signed [SW-1:0]     cur;
    logic signed [SW-1:0]     tgt;
    logic                     up;
    logic [vrl_pkg::MS_W-1:0] tms;
    logic signed [SW:0]       cur_x;
    logic signed [SW:0]       tgt_x;
    logic signed [SW:0]       nxt;
    logic signed [SW-1:0]     ramped;
    logic                     out_free;

    logic                     div_start;
    logic [NW-1:0]            div_num;
    logic [NW-1:0]            div_den;
    vrl_pkg::t_div_stat       div_stat;
    logic [NW-1:0]            div_quo;

    vrl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    always_comb begin
        lim = r_chan ? r_item.turn_limit : r_item.line_limit;
        cur = r_chan ? r_turn : r_lin;
        tgt = r_chan ? r_item.turn_tgt : r_item.lin_tgt;
        up  = (cur < tgt);
        if (r_chan) begin
            tms = up ? r_item.turn_acc_ms : r_item.turn_dec_ms;
        end else begin
            tms = up ? r_item.lin_acc_ms : r_item.lin_dec_ms;
        end
        cur_x = {cur[SW-1], cur};
        tgt_x = {tgt[SW-1], tgt};
        if (up) begin
            nxt    = cur_x + $signed({2'b00, r_step});
            ramped = (nxt < tgt_x) ? nxt[SW-1:0] : tgt;
        end else if (cur > tgt) begin
            nxt    = cur_x - $signed({2'b00, r_step});
            ramped = (nxt > tgt_x) ? nxt[SW-1:0] : tgt;
        end else begin
            nxt    = cur_x;
            ramped = cur;
        end
    end

    always_comb begin
        div_start = 1'b0;
        div_num   = NW'(tms) * vrl_pkg::US_PER_MS;
        div_den   = NW'(r_item.elapsed_us);
        if (r_state == ST_SETUP) begin
            div_start = (r_item.elapsed_us != '0);
        end else if (r_state == ST_DIV_Q) begin
            div_start = div_stat.done && (div_quo != '0);
            div_num   = NW'(lim);
            div_den   = div_quo;
        end
    end

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_item <= i_q_data;
        end
        case (r_state)
            ST_SETUP: begin
                if (r_item.elapsed_us == '0) begin
                    r_step <= '0;
                end
            end
            ST_DIV_Q: begin
                if (div_stat.done && div_quo == '0) begin
                    r_step <= lim;
                end
            end
            ST_DIV_S: begin
                if (div_stat.done) begin
                    r_step <= div_quo[LW-1:0];
                end
            end
            default: begin
            end
        endcase
        if (r_state == ST_DONE && out_free) begin
            r_out.speed_alarm <= r_item.speed_alarm;
            r_out.linear_out  <= r_lin;
            r_out.turn_out    <= r_turn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_chan      <= 1'b0;
            r_lin       <= '0;
            r_turn      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (!i_q_empty) begin
                        r_chan  <= 1'b0;
                        r_state <= ST_SETUP;
                    end
                end
                ST_SETUP: begin
                    r_state <= (r_item.elapsed_us == '0) ? ST_UPDATE : ST_DIV_Q;
                end
                ST_DIV_Q: begin
                    if (div_stat.done) begin
                        r_state <= (div_quo == '0) ? ST_UPDATE : ST_DIV_S;
                    end
                end
                ST_DIV_S: begin
                    if (div_stat.done) begin
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (r_chan) begin
                        r_turn  <= ramped;
                        r_state <= ST_DONE;
                    end else begin
                        r_lin   <= ramped;
                        r_chan  <= 1'b1;
                        r_state <= ST_SETUP;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_div_idle_on_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_stat.busy)
        else $error("Divider started while busy.");

    a_speed_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lin != 16'sh8000) && (r_turn != 16'sh8000))
        else $error("Smoothed speed reached the most negative code.");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("Result word loaded outside the final step.");

endmodule

`default_nettype wire
